@@ sv/qbz_pkg.sv @@
// Shared types and widths for the quadratic Bezier point generator.
`default_nettype none

package qbz_pkg;

   localparam int CoordWidth = 16;
   localparam int CountWidth = 7;
   localparam int IndexWidth = 6;
   localparam int StepWidth  = 17;
   localparam int RemWidth   = 6;
   localparam int FracWidth  = 16;

   typedef logic signed [CoordWidth-1:0] qbz_coord_type;

   // One job handed from the front to the back: control points and step plan.
   typedef struct packed {
      qbz_coord_type          first_x;
      qbz_coord_type          first_y;
      qbz_coord_type          middle_x;
      qbz_coord_type          middle_y;
      qbz_coord_type          end_x;
      qbz_coord_type          end_y;
      logic [CountWidth-1:0]  count;
      logic [StepWidth-1:0]   step;
      logic [RemWidth-1:0]    rem;
   } qbz_job_type;

endpackage

`default_nettype wire

@@ sv/qbz_front.sv @@
// Front end: accepts control points and divides 2^16 by the point count.
`default_nettype none

module qbz_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   output logic                         full,
   input  wire  qbz_pkg::qbz_coord_type req_first_x,
   input  wire  qbz_pkg::qbz_coord_type req_first_y,
   input  wire  qbz_pkg::qbz_coord_type req_middle_x,
   input  wire  qbz_pkg::qbz_coord_type req_middle_y,
   input  wire  qbz_pkg::qbz_coord_type req_end_x,
   input  wire  qbz_pkg::qbz_coord_type req_end_y,
   input  wire  [qbz_pkg::CountWidth-1:0] count_eff,
   output logic                         job_valid,
   input  wire                          job_ready,
   output qbz_pkg::qbz_job_type         job
);
   import qbz_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;

   localparam int StepCountWidth = $clog2(StepWidth);
   localparam logic [StepCountWidth-1:0] TopBit = StepCountWidth'(StepWidth - 1);

   logic [1:0]                state_ff, state_in;
   logic [StepCountWidth-1:0] bit_ff, bit_in;
   logic [RemWidth-1:0]       rem_ff, rem_in;
   logic [StepWidth-1:0]      quo_ff, quo_in;
   qbz_job_type               job_ff, job_in;
   logic [CountWidth-1:0]     partial;
   logic                      fits;

   // One quotient bit per cycle; the dividend is a one followed by zeros.
   assign partial = {rem_ff, (bit_ff == TopBit)};
   assign fits    = (partial >= job_ff.count);

   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      job_in   = job_ff;
      case (state_ff)
         ST_IDLE: begin
            if (push) begin
               job_in.first_x  = req_first_x;
               job_in.first_y  = req_first_y;
               job_in.middle_x = req_middle_x;
               job_in.middle_y = req_middle_y;
               job_in.end_x    = req_end_x;
               job_in.end_y    = req_end_y;
               job_in.count    = count_eff;
               bit_in          = TopBit;
               rem_in          = '0;
               quo_in          = '0;
               state_in        = ST_DIV;
            end
         end
         ST_DIV: begin
            if (fits) begin
               rem_in = RemWidth'(partial - job_ff.count);
            end else begin
               rem_in = RemWidth'(partial);
            end
            quo_in = {quo_ff[StepWidth-2:0], fits};
            if (bit_ff == '0) begin
               state_in = ST_PUSH;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         ST_PUSH: begin
            if (job_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bit_ff <= bit_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      job_ff <= job_in;
   end

   // The finished job carries the quotient and remainder of the division.
   always_comb begin
      job      = job_ff;
      job.step = quo_ff;
      job.rem  = rem_ff;
   end

   assign full      = (state_ff != ST_IDLE);
   assign job_valid = (state_ff == ST_PUSH);

   // The division must reproduce 2^16 exactly from quotient and remainder.
   a_div_exact: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH) |->
         (34'(quo_ff) * 34'(job_ff.count) + 34'(rem_ff) == 34'd65536))
      else $error("divider result does not reconstruct 2^16");

endmodule

`default_nettype wire

@@ sv/qbz_queue.sv @@
// Two-entry job queue between the front end and the point engine.
`default_nettype none

module qbz_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  wr_valid,
   output logic                 wr_full,
   input  wire  qbz_pkg::qbz_job_type wr_job,
   input  wire                  rd_pop,
   output logic                 rd_empty,
   output qbz_pkg::qbz_job_type rd_job
);
   import qbz_pkg::*;

   localparam int Depth = 2;

   qbz_job_type  mem_ff [Depth];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_write, do_read;

   assign wr_full  = (count_ff == 2'(Depth));
   assign rd_empty = (count_ff == 2'd0);
   assign rd_job   = mem_ff[rd_ptr_ff];
   assign do_write = wr_valid && !wr_full;
   assign do_read  = rd_pop && !rd_empty;

   // Pointers and occupancy follow the two handshakes.
   always_comb begin
      wr_ptr_in = do_write ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_read ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_write) - 2'(do_read);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_write) begin
         mem_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

`default_nettype wire

@@ sv/qbz_back.sv @@
// Point engine: steps t across a run and blends the control points.
`default_nettype none

module qbz_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  job_empty,
   input  wire  qbz_pkg::qbz_job_type job,
   output logic                 job_pop,
   output logic                 empty,
   input  wire                  pop,
   output qbz_pkg::qbz_coord_type rsp_curve_x,
   output qbz_pkg::qbz_coord_type rsp_curve_y,
   output logic [qbz_pkg::IndexWidth-1:0] rsp_point_index,
   output logic                 rsp_last_point
);
   import qbz_pkg::*;

   localparam int WaWidth   = 2 * FracWidth;
   localparam int WcWidth   = 2 * FracWidth + 1;
   localparam int ProdWidth = 50;
   localparam int SumWidth  = 52;
   localparam int HiWidth   = SumWidth - WaWidth;
   localparam logic signed [SumWidth-1:0] RoundHalf = SumWidth'(64'sd2147483648);
   localparam logic [FracWidth:0] One = 17'd65536;

   typedef struct packed {
      qbz_coord_type         first_x;
      qbz_coord_type         first_y;
      qbz_coord_type         middle_x;
      qbz_coord_type         middle_y;
      qbz_coord_type         end_x;
      qbz_coord_type         end_y;
      logic [IndexWidth-1:0] index;
      logic                  last;
   } qbz_tag_type;

   typedef struct packed {
      logic signed [ProdWidth-1:0] px_a;
      logic signed [ProdWidth-1:0] px_b;
      logic signed [ProdWidth-1:0] px_c;
      logic signed [ProdWidth-1:0] py_a;
      logic signed [ProdWidth-1:0] py_b;
      logic signed [ProdWidth-1:0] py_c;
      logic [IndexWidth-1:0]       index;
      logic                        last;
   } qbz_prod_type;

   // Run sequencer state.
   logic [IndexWidth-1:0] i_ff, i_in;
   logic [FracWidth-1:0]  t_ff, t_in;
   logic [RemWidth-1:0]   r_ff, r_in;

   logic                  adv, issue, last_pt, carry;
   logic [CountWidth-1:0] rsum;
   logic [StepWidth-1:0]  t_next;

   // Pipeline registers.
   logic                  s1_valid_ff;
   logic [FracWidth-1:0]  s1_t_ff;
   logic [FracWidth:0]    s1_u_ff;
   qbz_tag_type           s1_tag_ff, s1_tag_in;

   logic                  s2_valid_ff;
   logic [WaWidth-1:0]    s2_wa_ff;
   logic [WaWidth-1:0]    s2_wb_ff;
   logic [WcWidth-1:0]    s2_wc_ff;
   qbz_tag_type           s2_tag_ff;

   logic                  s3_valid_ff;
   qbz_prod_type          s3_ff, s3_in;

   logic                  out_valid_ff;
   qbz_coord_type         out_x_ff, out_x_in;
   qbz_coord_type         out_y_ff, out_y_in;
   logic [IndexWidth-1:0] out_index_ff;
   logic                  out_last_ff;

   logic [WaWidth+1:0]    tu_prod;
   logic [WcWidth+1:0]    uu_prod;
   logic signed [WcWidth:0] wa_s, wb_s, wc_s;

   // The whole pipeline moves whenever the output register can take a beat.
   assign adv     = !out_valid_ff || pop;
   assign issue   = adv && !job_empty;
   assign last_pt = ((CountWidth'(i_ff) + 1'b1) == job.count);
   assign job_pop = issue && last_pt;

   // t advances by the quotient, plus one when the remainder sum wraps.
   assign rsum   = CountWidth'(r_ff) + CountWidth'(job.rem);
   assign carry  = (rsum >= job.count);
   assign t_next = StepWidth'(t_ff) + job.step + StepWidth'(carry);

   always_comb begin
      i_in = i_ff;
      t_in = t_ff;
      r_in = r_ff;
      if (issue) begin
         if (last_pt) begin
            i_in = '0;
            t_in = '0;
            r_in = '0;
         end else begin
            i_in = i_ff + 1'b1;
            t_in = t_next[FracWidth-1:0];
            r_in = carry ? RemWidth'(rsum - job.count) : RemWidth'(rsum);
         end
      end
   end

   always_comb begin
      s1_tag_in.first_x  = job.first_x;
      s1_tag_in.first_y  = job.first_y;
      s1_tag_in.middle_x = job.middle_x;
      s1_tag_in.middle_y = job.middle_y;
      s1_tag_in.end_x    = job.end_x;
      s1_tag_in.end_y    = job.end_y;
      s1_tag_in.index    = i_ff;
      s1_tag_in.last     = last_pt;
   end

   // Weights: t^2 and 2t(1-t) in Q0.32, (1-t)^2 in Q1.32.
   assign tu_prod = (WaWidth+2)'(s1_t_ff) * (WaWidth+2)'(s1_u_ff);
   assign uu_prod = (WcWidth+2)'(s1_u_ff) * (WcWidth+2)'(s1_u_ff);

   // Coordinate products; the weights are non-negative.
   assign wa_s = {2'b00, s2_wa_ff};
   assign wb_s = {2'b00, s2_wb_ff};
   assign wc_s = {1'b0, s2_wc_ff};

   always_comb begin
      s3_in.px_a  = wa_s * s2_tag_ff.first_x;
      s3_in.px_b  = wb_s * s2_tag_ff.middle_x;
      s3_in.px_c  = wc_s * s2_tag_ff.end_x;
      s3_in.py_a  = wa_s * s2_tag_ff.first_y;
      s3_in.py_b  = wb_s * s2_tag_ff.middle_y;
      s3_in.py_c  = wc_s * s2_tag_ff.end_y;
      s3_in.index = s2_tag_ff.index;
      s3_in.last  = s2_tag_ff.last;
   end

   // Sum, round half up and saturate to Q11.4.
   function automatic qbz_coord_type blend(input logic signed [ProdWidth-1:0] a,
                                           input logic signed [ProdWidth-1:0] b,
                                           input logic signed [ProdWidth-1:0] c);
      logic signed [SumWidth-1:0] sum;
      logic signed [SumWidth-1:0] shifted;
      logic signed [HiWidth-1:0]  hi;
      qbz_coord_type              res;
      sum     = SumWidth'(a) + SumWidth'(b) + SumWidth'(c) + RoundHalf;
      shifted = sum >>> WaWidth;
      hi      = shifted[HiWidth-1:0];
      if (hi > HiWidth'(32767)) begin
         res = 16'sh7FFF;
      end else if (hi < -HiWidth'(32768)) begin
         res = 16'sh8000;
      end else begin
         res = hi[CoordWidth-1:0];
      end
      return res;
   endfunction

   assign out_x_in = blend(s3_ff.px_a, s3_ff.px_b, s3_ff.px_c);
   assign out_y_in = blend(s3_ff.py_a, s3_ff.py_b, s3_ff.py_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         t_ff         <= '0;
         r_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         i_ff <= i_in;
         t_ff <= t_in;
         r_ff <= r_in;
         if (adv) begin
            s1_valid_ff  <= issue;
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff;
            out_valid_ff <= s3_valid_ff;
         end
      end
      if (adv) begin
         s1_t_ff      <= t_ff;
         s1_u_ff      <= One - (FracWidth+1)'(t_ff);
         s1_tag_ff    <= s1_tag_in;
         s2_wa_ff     <= WaWidth'(s1_t_ff) * WaWidth'(s1_t_ff);
         s2_wb_ff     <= WaWidth'({tu_prod[WaWidth:0], 1'b0});
         s2_wc_ff     <= uu_prod[WcWidth-1:0];
         s2_tag_ff    <= s1_tag_ff;
         s3_ff        <= s3_in;
         out_x_ff     <= out_x_in;
         out_y_ff     <= out_y_in;
         out_index_ff <= s3_ff.index;
         out_last_ff  <= s3_ff.last;
      end
   end

   assign empty           = !out_valid_ff;
   assign rsp_curve_x     = out_x_ff;
   assign rsp_curve_y     = out_y_ff;
   assign rsp_point_index = out_index_ff;
   assign rsp_last_point  = out_last_ff;

   // A run always starts from t = 0 with a clear remainder.
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (issue && (i_ff == '0)) |-> ((t_ff == '0) && (r_ff == '0)))
      else $error("run started with stale step state");

   // The running remainder stays below the point count.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      !job_empty |-> (CountWidth'(r_ff) < job.count))
      else $error("step remainder out of range");

endmodule

`default_nettype wire

@@ sv/quadratic_bezier_point_generator.sv @@
// Quadratic Bezier point generator: top level with the point count register.
//
// Usage: one input beat (push/full) carries three control points in signed
// Q11.4. For each beat the block emits N result beats on the empty/pop side,
// N being the point count register clamped to 1..MAX_POINTS (zero reads as
// one). Point i uses t = floor(i * 2^16 / N); the first point equals the end
// point and the final point of a run carries rsp_last_point.
// The count register is written on the csr channel, which is always ready;
// write it only while the block is idle.
// Path from an accepted beat to its first point: bit-serial division of
// 2^16 by N into a 17-bit quotient, a queue hop, four pipeline stages.
// Throughput: one point per cycle while pop is not held off, though the
// divider, which overlaps with the previous run through a two-entry job
// queue, can hold back short runs.
// Reset empties the pipeline and queue and sets the point count to 64.
// When the receiver holds off pop, the point pipeline stalls as a whole;
// the front end still takes and prepares up to three more beats.
`default_nettype none

module quadratic_bezier_point_generator #(
   parameter int MAX_POINTS = 64
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              push,
   output logic                             full,
   input  wire  qbz_pkg::qbz_coord_type     req_first_x,
   input  wire  qbz_pkg::qbz_coord_type     req_first_y,
   input  wire  qbz_pkg::qbz_coord_type     req_middle_x,
   input  wire  qbz_pkg::qbz_coord_type     req_middle_y,
   input  wire  qbz_pkg::qbz_coord_type     req_end_x,
   input  wire  qbz_pkg::qbz_coord_type     req_end_y,
   output logic                             empty,
   input  wire                              pop,
   output qbz_pkg::qbz_coord_type           rsp_curve_x,
   output qbz_pkg::qbz_coord_type           rsp_curve_y,
   output logic [qbz_pkg::IndexWidth-1:0]   rsp_point_index,
   output logic                             rsp_last_point,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [qbz_pkg::CountWidth-1:0]   csr_point_count
);
   import qbz_pkg::*;

   localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MAX_POINTS);

   logic [CountWidth-1:0] point_count_ff, point_count_in;
   logic [CountWidth-1:0] count_eff;
   logic                  fq_valid, fq_full, q_empty, q_pop;
   qbz_job_type           fq_job, q_job;

   // Configuration register, written whenever the csr channel presents a beat.
   assign csr_ready      = 1'b1;
   assign point_count_in = (csr_valid && csr_ready) ? csr_point_count : point_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 7'd64;
      end else begin
         point_count_ff <= point_count_in;
      end
   end

   // Clamp the count into the supported range.
   always_comb begin
      if (point_count_ff == '0) begin
         count_eff = CountWidth'(1);
      end else if (point_count_ff > MaxCount) begin
         count_eff = MaxCount;
      end else begin
         count_eff = point_count_ff;
      end
   end

   qbz_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_middle_x (req_middle_x),
      .req_middle_y (req_middle_y),
      .req_end_x    (req_end_x),
      .req_end_y    (req_end_y),
      .count_eff    (count_eff),
      .job_valid    (fq_valid),
      .job_ready    (!fq_full),
      .job          (fq_job)
   );

   qbz_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_full  (fq_full),
      .wr_job   (fq_job),
      .rd_pop   (q_pop),
      .rd_empty (q_empty),
      .rd_job   (q_job)
   );

   qbz_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_empty       (q_empty),
      .job             (q_job),
      .job_pop         (q_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_curve_x     (rsp_curve_x),
      .rsp_curve_y     (rsp_curve_y),
      .rsp_point_index (rsp_point_index),
      .rsp_last_point  (rsp_last_point)
   );

endmodule

`default_nettype wire
